[src/urt_pkg.sv]
// ----------------------------------------------------------------------------
// urt_pkg: shared types and constants of the unique record table
// Command and status codes, beat structs and the entry layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package urt_pkg;

  localparam int TABLE_DEPTH_DEF = 512;

  localparam logic [15:0] ID_MASK  = 16'h3FFF;
  localparam logic [15:0] NEW_MARK = 16'h8000;

  localparam int TOTAL_W = 10;
  localparam int SLOT_W  = 9;

  // command codes
  localparam logic [2:0] CMD_INIT   = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_LOOKUP = 3'd2;
  localparam logic [2:0] CMD_READ   = 3'd3;
  localparam logic [2:0] CMD_TAKE   = 3'd4;

  // status codes
  localparam logic [1:0] STS_DONE = 2'd0;
  localparam logic [1:0] STS_DUP  = 2'd1;
  localparam logic [1:0] STS_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]        command;
    logic [13:0]       record_id;
    logic [31:0]       first_value;
    logic [31:0]       second_value;
    logic [SLOT_W-1:0] slot_index;
  } cmd_t;

  typedef struct packed {
    logic               found;
    logic [31:0]        first_out;
    logic [31:0]        second_out;
    logic [15:0]        entry_word;
    logic               any_new;
    logic [TOTAL_W-1:0] entry_total;
    logic [1:0]         status;
  } rsp_t;

  // one table entry as held in a cell
  typedef struct packed {
    logic [15:0] word;
    logic [31:0] first;
    logic [31:0] second;
  } entry_t;

endpackage

[src/urt_cell.sv]
// ----------------------------------------------------------------------------
// urt_cell: one entry of the circulating table
// Holds an entry word and its two values; loads its neighbor when shifting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urt_cell import urt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   shift,
  input  entry_t d,
  output entry_t q
);

  // entry word resets to zero, values are undefined until written
  always_ff @(posedge clk) begin
    if (rst) begin
      q.word <= '0;
    end else if (shift) begin
      q.word <= d.word;
    end
    if (shift) begin
      q.first  <= d.first;
      q.second <= d.second;
    end
  end

endmodule

[src/unique_record_table_unit.sv]
// ----------------------------------------------------------------------------
// unique_record_table_unit: append-only table of unique 14-bit ids
// Entries sit in a ring of cells that rotates once per command.
// ----------------------------------------------------------------------------
// Each command runs from accept through a scan and a done state back to
// idle, where the next is accepted: the table lives in a ring of
// TABLE_DEPTH cells that rotates by one entry a cycle, and every command
// rotates it once fully so that each entry passes the head cell, where it is
// compared, read, marked or replaced. One command is worked at a time; a new
// command is taken while the previous response still waits in the output
// register. Response beats follow command beats in order, one for one.
`timescale 1ns / 1ps

module unique_record_table_unit import urt_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = (CW > SLOT_W) ? CW : SLOT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]    state;
  cmd_t          op;
  logic [CW-1:0] count;
  logic [CW-1:0] step;
  logic          hit;
  logic          wrote;
  logic          any;
  logic [31:0]   cap_first;
  logic [31:0]   cap_second;
  logic [15:0]   cap_word;

  entry_t        cell_q [TABLE_DEPTH];
  entry_t        head;
  entry_t        feedback;
  logic          shift;
  logic          in_use;
  logic          match;
  logic          last_step;
  logic          out_free;
  logic [CW-1:0] count_next;

  assign shift     = (state == ST_SCAN);
  assign cmd_ready = (state == ST_IDLE);
  assign head      = cell_q[0];
  assign in_use    = (step < count);
  assign match     = in_use && (head.word[13:0] == op.record_id);
  assign last_step = (step == CW'(TABLE_DEPTH - 1));
  assign out_free  = !rsp_valid || rsp_ready;

  // entry leaving the head goes back into the tail, edited by the command
  always_comb begin
    feedback = head;
    case (op.command)
      CMD_INIT: begin
        feedback.word = '0;
      end
      CMD_INSERT: begin
        if (step == count && !hit) begin
          feedback.word   = NEW_MARK | {2'b00, op.record_id};
          feedback.first  = op.first_value;
          feedback.second = op.second_value;
        end
      end
      CMD_TAKE: begin
        if (in_use) begin
          feedback.word = head.word & ID_MASK;
        end
      end
      default: begin
      end
    endcase
  end

  // ring of cells, each loading its upper neighbor
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    entry_t d;
    if (k == TABLE_DEPTH - 1) begin : g_tail
      assign d = feedback;
    end else begin : g_body
      assign d = cell_q[k + 1];
    end
    urt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     (d),
      .q     (cell_q[k])
    );
  end

  // count after the command
  always_comb begin
    count_next = count;
    if (op.command == CMD_INIT) begin
      count_next = '0;
    end else if (wrote) begin
      count_next = count + 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      step      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            state <= ST_SCAN;
            step  <= '0;
          end
        end
        ST_SCAN: begin
          step <= step + 1'b1;
          if (last_step) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            count <= count_next;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // per-command capture at the head cell
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid) begin
      op         <= cmd;
      hit        <= 1'b0;
      wrote      <= 1'b0;
      any        <= 1'b0;
      cap_first  <= '0;
      cap_second <= '0;
      cap_word   <= '0;
    end else if (state == ST_SCAN) begin
      case (op.command)
        CMD_INSERT: begin
          if (match) begin
            hit <= 1'b1;
          end
          if (step == count && !hit) begin
            wrote <= 1'b1;
          end
        end
        CMD_LOOKUP: begin
          if (match) begin
            hit        <= 1'b1;
            cap_first  <= head.first;
            cap_second <= head.second;
          end
        end
        CMD_READ: begin
          if (SW'(step) == SW'(op.slot_index)) begin
            cap_word <= head.word;
          end
        end
        CMD_TAKE: begin
          if (in_use && head.word[15]) begin
            any <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // response beat
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      rsp.found       <= hit && (op.command == CMD_INSERT || op.command == CMD_LOOKUP);
      rsp.first_out   <= cap_first;
      rsp.second_out  <= cap_second;
      rsp.entry_word  <= (op.command == CMD_READ && count != '0) ? cap_word : 16'h0000;
      rsp.any_new     <= any && (op.command == CMD_TAKE);
      rsp.entry_total <= TOTAL_W'(count_next);
      if (op.command == CMD_INSERT) begin
        rsp.status <= hit ? STS_DUP : (wrote ? STS_DONE : STS_FULL);
      end else begin
        rsp.status <= STS_DONE;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_rsp_after_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_DONE))
    else $error("response raised without a finished scan");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |=> !(cmd_ready && state == ST_IDLE && $past(!last_step)))
    else $error("command accepted mid-scan");

  a_single_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && wrote) |-> !(step == count))
    else $error("second append in one insert");
`endif

endmodule
